>>> sv/jpq_pkg.sv
// ----------------------------------------------------------------------------
// jpq_pkg
// Shared types and codes of the job priority queue: entry record, opcodes,
// result status codes and the compare unit's flags.
// ----------------------------------------------------------------------------
package jpq_pkg;

  localparam int DEF_CAPACITY = 16;

  // opcodes
  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_POP       = 3'd1;
  localparam logic [2:0] OP_LIST_USER = 3'd2;
  localparam logic [2:0] OP_LIST_RES  = 3'd3;
  localparam logic [2:0] OP_LIST_ALL  = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  // result status
  localparam logic [1:0] ST_RECORD = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  typedef struct packed {
    logic [31:0]        job_tag;
    logic [31:0]        user_tag;
    logic [7:0]         cpu_count;
    logic [7:0]         gpu_count;
    logic [15:0]        memory_amount;
    logic [19:0]        run_time;
    logic signed [15:0] prio;
  } job_rec_t;

  typedef struct packed {
    logic hit;         // entry matches the list query
    logic stays_ahead; // entry priority >= new job priority
  } cmp_t;

endpackage

>>> sv/jpq_match.sv
// ----------------------------------------------------------------------------
// jpq_match
// Compare unit shared by the insert and list walks over the table: list match test and the
// priority test that finds the insert slot.
// ----------------------------------------------------------------------------
module jpq_match
  import jpq_pkg::*;
(
  input  logic [2:0] op,
  input  job_rec_t   entry,
  input  job_rec_t   query,
  output cmp_t       cmp
);

  always_comb begin
    cmp.stays_ahead = ($signed(entry.prio) >= $signed(query.prio));
    unique case (op)
      OP_LIST_USER: begin
        cmp.hit = (entry.user_tag == query.user_tag);
      end
      OP_LIST_RES: begin
        cmp.hit = (entry.cpu_count == query.cpu_count) &&
                  (entry.gpu_count == query.gpu_count) &&
                  (entry.memory_amount == query.memory_amount) &&
                  (entry.run_time == query.run_time);
      end
      OP_LIST_ALL: begin
        cmp.hit = 1'b1;
      end
      default: begin
        cmp.hit = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/job_priority_queue.sv
// ----------------------------------------------------------------------------
// job_priority_queue
// Bounded job table kept sorted by descending priority, stable for equal
// priorities, with pop, three list operations and clear.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_*: one command beat (opcode plus job fields). in_stall
//    is high while a command is being worked; one command at a time.
//  - Result channel out_*: one or more beats per command, out_last marks the
//    final one. Unused opcodes give no beat.
//  - Command time grows with the entries walked and with out_stall. It is set
//    by the single-port table, read once per step with registered read data,
//    so each entry visited takes a read state and a compare/write state.
//  - A list holds back one match so out_last can go on the true final beat.
//  - The result register parts the two sides; while out_stall is high the
//    beat holds and the walk pauses where it needs the output next.
//  - Reset empties the table (count to zero); contents need no clearing.
// ----------------------------------------------------------------------------
module job_priority_queue
  import jpq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [31:0]        in_job_tag,
  input  logic [31:0]        in_user_tag,
  input  logic [7:0]         in_cpu_count,
  input  logic [7:0]         in_gpu_count,
  input  logic [15:0]        in_memory_amount,
  input  logic [19:0]        in_run_time,
  input  logic signed [15:0] in_priority_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [31:0]        out_job_tag,
  output logic [31:0]        out_user_tag,
  output logic [7:0]         out_cpu_count,
  output logic [7:0]         out_gpu_count,
  output logic [15:0]        out_memory_amount,
  output logic [19:0]        out_run_time,
  output logic signed [15:0] out_priority,
  output logic               out_last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_INS_RD    = 4'd1;
  localparam logic [3:0] S_INS_EV    = 4'd2;
  localparam logic [3:0] S_POP_RD    = 4'd3;
  localparam logic [3:0] S_POP_EV    = 4'd4;
  localparam logic [3:0] S_POP_SH_RD = 4'd5;
  localparam logic [3:0] S_POP_SH_WR = 4'd6;
  localparam logic [3:0] S_LS_RD     = 4'd7;
  localparam logic [3:0] S_LS_EV     = 4'd8;
  localparam logic [3:0] S_LS_END    = 4'd9;
  localparam logic [3:0] S_EMIT      = 4'd10;

  // table
  job_rec_t table_mem [CAPACITY];
  job_rec_t rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  job_rec_t      wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= table_mem[rd_addr];
  end

  // control state
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          hold_v_r, hold_v_nxt;
  job_rec_t      hold_r, hold_nxt;
  logic [2:0]    op_r, op_nxt;
  job_rec_t      q_r, q_nxt;
  logic [1:0]    emit_st_r, emit_st_nxt;

  // result register
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  job_rec_t      out_rec_r;
  logic          out_last_r;

  logic          out_free;
  logic          out_load;
  logic [1:0]    ld_status;
  job_rec_t      ld_rec;
  logic          ld_last;

  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  cmp_t          cmp;

  jpq_match u_match (
    .op    (op_r),
    .entry (rd_data_r),
    .query (q_r),
    .cmp   (cmp)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign idx_inc  = idx_r + CW'(1);
  assign idx_dec  = idx_r - CW'(1);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    hold_v_nxt  = hold_v_r;
    hold_nxt    = hold_r;
    op_nxt      = op_r;
    q_nxt       = q_r;
    emit_st_nxt = emit_st_r;
    rd_addr     = idx_r[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx_r[AW-1:0];
    wr_data     = q_r;
    out_load    = 1'b0;
    ld_status   = ST_RECORD;
    ld_rec      = '0;
    ld_last     = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_opcode;
          q_nxt   = '{in_job_tag, in_user_tag, in_cpu_count, in_gpu_count,
                      in_memory_amount, in_run_time, in_priority_req};
          idx_nxt = '0;
          hold_v_nxt = 1'b0;
          unique case (in_opcode)
            OP_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                emit_st_nxt = ST_FULL;
                state_nxt   = S_EMIT;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_INS_RD;
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                emit_st_nxt = ST_NONE;
                state_nxt   = S_EMIT;
              end else begin
                state_nxt = S_POP_RD;
              end
            end
            OP_LIST_USER, OP_LIST_RES, OP_LIST_ALL: begin
              state_nxt = (count_r == '0) ? S_LS_END : S_LS_RD;
            end
            OP_CLEAR: begin
              count_nxt   = '0;
              emit_st_nxt = ST_DONE;
              state_nxt   = S_EMIT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // walk up from the tail, shifting entries down until one stays ahead
      S_INS_RD: begin
        if (idx_r == '0) begin
          wr_en       = 1'b1;
          count_nxt   = count_r + CW'(1);
          emit_st_nxt = ST_DONE;
          state_nxt   = S_EMIT;
        end else begin
          rd_addr   = idx_dec[AW-1:0];
          state_nxt = S_INS_EV;
        end
      end

      S_INS_EV: begin
        wr_en = 1'b1;
        if (cmp.stays_ahead) begin
          count_nxt   = count_r + CW'(1);
          emit_st_nxt = ST_DONE;
          state_nxt   = S_EMIT;
        end else begin
          wr_data   = rd_data_r;
          idx_nxt   = idx_dec;
          state_nxt = S_INS_RD;
        end
      end

      S_POP_RD: begin
        state_nxt = S_POP_EV;
      end

      S_POP_EV: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_rec   = rd_data_r;
          if (count_r == CW'(1)) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = CW'(1);
            state_nxt = S_POP_SH_RD;
          end
        end
      end

      S_POP_SH_RD: begin
        state_nxt = S_POP_SH_WR;
      end

      S_POP_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_dec[AW-1:0];
        wr_data = rd_data_r;
        if (idx_inc == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_POP_SH_RD;
        end
      end

      S_LS_RD: begin
        state_nxt = S_LS_EV;
      end

      // one match is held back so the final beat can carry last
      S_LS_EV: begin
        if (!(cmp.hit && hold_v_r && !out_free)) begin
          if (cmp.hit) begin
            if (hold_v_r) begin
              out_load = 1'b1;
              ld_rec   = hold_r;
              ld_last  = 1'b0;
            end
            hold_nxt   = rd_data_r;
            hold_v_nxt = 1'b1;
          end
          if (idx_inc == count_r) begin
            state_nxt = S_LS_END;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_LS_RD;
          end
        end
      end

      S_LS_END: begin
        if (out_free) begin
          out_load = 1'b1;
          if (hold_v_r) begin
            ld_rec = hold_r;
          end else begin
            ld_status = ST_NONE;
          end
          state_nxt = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = emit_st_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      hold_v_r <= hold_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    hold_r    <= hold_nxt;
    op_r      <= op_nxt;
    q_r       <= q_nxt;
    emit_st_r <= emit_st_nxt;
    if (out_load) begin
      out_status_r <= ld_status;
      out_rec_r    <= ld_rec;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_job_tag       = out_rec_r.job_tag;
  assign out_user_tag      = out_rec_r.user_tag;
  assign out_cpu_count     = out_rec_r.cpu_count;
  assign out_gpu_count     = out_rec_r.gpu_count;
  assign out_memory_amount = out_rec_r.memory_amount;
  assign out_run_time      = out_rec_r.run_time;
  assign out_priority      = out_rec_r.prio;
  assign out_last          = out_last_r;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for job_priority_queue. A short stimulus table covers
// the empty and full table, the priority extremes, ties and every opcode;
// random commands then run under several idle/stall mixes, including one long
// receiver hold-off. Every result beat is checked against an in-bench model of
// the sorted job table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import jpq_pkg::*;
();

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int PHASE_ITEMS  = 80;
  localparam int FILL_BURST   = 17;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  // opcodes the block ignores
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int TX_IDLE  [4] = '{0, 54, 0, 20};
  localparam int RX_STALL [4] = '{0, 0, 54, 20};

  localparam logic [31:0] USER_A = 32'hA5A5_5A5A;
  localparam logic [31:0] USER_B = 32'h0000_0001;
  localparam logic [31:0] USER_POOL [4] = '{USER_A, USER_B, 32'hFFFF_FFFF, 32'h1234_5678};
  localparam logic signed [15:0] PRIO_POOL [5] =
    '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};
  localparam logic signed [15:0] FILL_PRIO [14] =
    '{16'sd0, 16'sd0, 16'sd100, -16'sd1, 16'sh7FFF, 16'sd0, 16'sh8000,
      16'sd5, 16'sd5, 16'sd5, -16'sd100, 16'sd1, 16'sd0, 16'sd2};

  typedef struct packed {
    logic [2:0] opcode;
    job_rec_t   job;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    job_rec_t   rec;
    logic       last;
  } beat_t;

  typedef struct {
    cmd_t       cmd;
    bit         typed;
    logic [1:0] status;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_opcode;
  logic [31:0]        in_job_tag;
  logic [31:0]        in_user_tag;
  logic [7:0]         in_cpu_count;
  logic [7:0]         in_gpu_count;
  logic [15:0]        in_memory_amount;
  logic [19:0]        in_run_time;
  logic signed [15:0] in_priority_req;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [31:0]        out_job_tag;
  logic [31:0]        out_user_tag;
  logic [7:0]         out_cpu_count;
  logic [7:0]         out_gpu_count;
  logic [15:0]        out_memory_amount;
  logic [19:0]        out_run_time;
  logic signed [15:0] out_priority;
  logic               out_last;

  job_priority_queue #(.CAPACITY(CAPACITY)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_job_tag        (in_job_tag),
    .in_user_tag       (in_user_tag),
    .in_cpu_count      (in_cpu_count),
    .in_gpu_count      (in_gpu_count),
    .in_memory_amount  (in_memory_amount),
    .in_run_time       (in_run_time),
    .in_priority_req   (in_priority_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_job_tag       (out_job_tag),
    .out_user_tag      (out_user_tag),
    .out_cpu_count     (out_cpu_count),
    .out_gpu_count     (out_gpu_count),
    .out_memory_amount (out_memory_amount),
    .out_run_time      (out_run_time),
    .out_priority      (out_priority),
    .out_last          (out_last)
  );

  // model of the job table
  job_rec_t job_slots [CAPACITY];
  int       job_count = 0;
  beat_t    step_beats [$];
  beat_t    expected_beats [$];

  int  errors        = 0;
  int  cmds_sent     = 0;
  int  directed_cmds = 0;
  int  beats_seen    = 0;
  int  refused_seen  = 0;
  int  tx_pct        = 0;
  int  rx_pct        = 0;
  int  hold_left     = 0;
  bit  hold_request  = 1'b0;

  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic beat_t status_beat(logic [1:0] st);
    beat_t b;
    b        = '0;
    b.status = st;
    b.last   = 1'b1;
    return b;
  endfunction

  function automatic bit entry_matches(cmd_t c, int i);
    case (c.opcode)
      OP_LIST_USER: return job_slots[i].user_tag == c.job.user_tag;
      OP_LIST_RES:  return job_slots[i].cpu_count == c.job.cpu_count &&
                           job_slots[i].gpu_count == c.job.gpu_count &&
                           job_slots[i].memory_amount == c.job.memory_amount &&
                           job_slots[i].run_time == c.job.run_time;
      default:      return 1'b1;
    endcase
  endfunction

  // Updates the table model and leaves the beats the command causes in step_beats.
  function automatic void apply_command(cmd_t c);
    int    pos;
    int    hits;
    int    seen;
    beat_t b;
    step_beats.delete();
    case (c.opcode)
      OP_INSERT: begin
        if (job_count >= CAPACITY) begin
          step_beats.push_back(status_beat(ST_FULL));
        end else begin
          // new job goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < job_count && $signed(job_slots[pos].prio) >= $signed(c.job.prio))
            pos++;
          for (int i = job_count; i > pos; i--)
            job_slots[i] = job_slots[i - 1];
          job_slots[pos] = c.job;
          job_count++;
          step_beats.push_back(status_beat(ST_DONE));
        end
      end
      OP_POP: begin
        if (job_count == 0) begin
          step_beats.push_back(status_beat(ST_NONE));
        end else begin
          b        = '0;
          b.status = ST_RECORD;
          b.rec    = job_slots[0];
          b.last   = 1'b1;
          step_beats.push_back(b);
          for (int i = 1; i < job_count; i++)
            job_slots[i - 1] = job_slots[i];
          job_count--;
        end
      end
      OP_LIST_USER, OP_LIST_RES, OP_LIST_ALL: begin
        hits = 0;
        for (int i = 0; i < job_count; i++)
          if (entry_matches(c, i)) hits++;
        if (hits == 0) begin
          step_beats.push_back(status_beat(ST_NONE));
        end else begin
          seen = 0;
          for (int i = 0; i < job_count; i++) begin
            if (entry_matches(c, i)) begin
              seen++;
              b        = '0;
              b.status = ST_RECORD;
              b.rec    = job_slots[i];
              b.last   = (seen == hits);
              step_beats.push_back(b);
            end
          end
        end
      end
      OP_CLEAR: begin
        job_count = 0;
        step_beats.push_back(status_beat(ST_DONE));
      end
      default: ;
    endcase
  endfunction

  function automatic cmd_t random_command(bit force_insert);
    cmd_t c;
    int   roll;
    int   pick;
    roll             = $urandom_range(99);
    c.job.job_tag    = $urandom;
    c.job.user_tag   = ($urandom_range(99) < 70) ? USER_POOL[$urandom_range(3)] : $urandom;
    if ($urandom_range(99) < 60) begin
      c.job.cpu_count     = 8'($urandom_range(3));
      c.job.gpu_count     = 8'($urandom_range(1));
      c.job.memory_amount = 16'($urandom_range(3));
      c.job.run_time      = 20'($urandom_range(3));
    end else begin
      c.job.cpu_count     = 8'($urandom);
      c.job.gpu_count     = 8'($urandom);
      c.job.memory_amount = 16'($urandom);
      c.job.run_time      = 20'($urandom);
    end
    c.job.prio = ($urandom_range(99) < 50) ? PRIO_POOL[$urandom_range(4)] : 16'($urandom);

    if (force_insert || roll < 40)  c.opcode = OP_INSERT;
    else if (roll < 55)             c.opcode = OP_POP;
    else if (roll < 67)             c.opcode = OP_LIST_USER;
    else if (roll < 80)             c.opcode = OP_LIST_RES;
    else if (roll < 92)             c.opcode = OP_LIST_ALL;
    else if (roll < 96)             c.opcode = OP_CLEAR;
    else                            c.opcode = roll[0] ? OP_SPARE_A : OP_SPARE_B;

    // aim most queries at stored entries so the lists report something
    if (job_count > 0 && $urandom_range(99) < 55) begin
      pick = $urandom_range(job_count - 1);
      if (c.opcode == OP_LIST_USER) c.job.user_tag = job_slots[pick].user_tag;
      if (c.opcode == OP_LIST_RES) begin
        c.job.cpu_count     = job_slots[pick].cpu_count;
        c.job.gpu_count     = job_slots[pick].gpu_count;
        c.job.memory_amount = job_slots[pick].memory_amount;
        c.job.run_time      = job_slots[pick].run_time;
      end
    end
    return c;
  endfunction

  function automatic dir_row_t mk_row(logic [2:0] op, job_rec_t j, bit typed,
                                      logic [1:0] st);
    dir_row_t r;
    r.cmd.opcode = op;
    r.cmd.job    = j;
    r.typed      = typed;
    r.status     = st;
    return r;
  endfunction

  function automatic void build_directed();
    job_rec_t j;
    job_rec_t res;
    res               = '0;
    res.cpu_count     = 8'd4;
    res.gpu_count     = 8'd1;
    res.memory_amount = 16'd1024;
    res.run_time      = 20'd36000;

    j = '0;
    dir_rows.push_back(mk_row(OP_POP,      j, 1'b1, ST_NONE));
    dir_rows.push_back(mk_row(OP_LIST_ALL, j, 1'b1, ST_NONE));
    j      = '1;
    j.prio = 16'sh7FFF;
    dir_rows.push_back(mk_row(OP_INSERT, j, 1'b1, ST_DONE));
    j      = '0;
    j.prio = 16'sh8000;
    dir_rows.push_back(mk_row(OP_INSERT, j, 1'b1, ST_DONE));
    for (int i = 0; i < 14; i++) begin
      if (i % 3 == 0) begin
        j = res;
      end else begin
        j.cpu_count     = 8'(i);
        j.gpu_count     = 8'(i >> 1);
        j.memory_amount = 16'(i * 100);
        j.run_time      = 20'(i * 1000);
      end
      j.job_tag  = 32'h0000_0100 + 32'(i);
      j.user_tag = (i % 2) ? USER_A : USER_B;
      j.prio     = FILL_PRIO[i];
      dir_rows.push_back(mk_row(OP_INSERT, j, 1'b1, ST_DONE));
    end
    // table now holds sixteen jobs
    j = '0;
    dir_rows.push_back(mk_row(OP_INSERT, j, 1'b1, ST_FULL));
    j.user_tag = USER_A;
    dir_rows.push_back(mk_row(OP_LIST_USER, j, 1'b0, ST_RECORD));
    dir_rows.push_back(mk_row(OP_LIST_RES, res, 1'b0, ST_RECORD));
    j           = res;
    j.cpu_count = 8'h5A;
    dir_rows.push_back(mk_row(OP_LIST_RES, j, 1'b0, ST_RECORD));
    j = '0;
    dir_rows.push_back(mk_row(OP_LIST_ALL, j, 1'b0, ST_RECORD));
    dir_rows.push_back(mk_row(OP_SPARE_B,  j, 1'b0, ST_RECORD));
    dir_rows.push_back(mk_row(OP_POP,      j, 1'b0, ST_RECORD));
    dir_rows.push_back(mk_row(OP_CLEAR,    j, 1'b1, ST_DONE));
  endfunction

  // Offers one command beat, waits for it to be taken and books its results.
  task automatic issue(cmd_t c, bit typed, logic [1:0] st);
    while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= c.opcode;
    in_job_tag       <= c.job.job_tag;
    in_user_tag      <= c.job.user_tag;
    in_cpu_count     <= c.job.cpu_count;
    in_gpu_count     <= c.job.gpu_count;
    in_memory_amount <= c.job.memory_amount;
    in_run_time      <= c.job.run_time;
    in_priority_req  <= c.job.prio;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_command(c);
    if (typed) begin
      step_beats.delete();
      step_beats.push_back(status_beat(st));
    end
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    cmds_sent++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // receiver: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    beat_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      beats_seen++;
      if (out_status == ST_FULL) refused_seen++;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected, status %0d", out_status);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        check_field("status",        32'(want.status),            32'(out_status));
        check_field("job_tag",       want.rec.job_tag,            out_job_tag);
        check_field("user_tag",      want.rec.user_tag,           out_user_tag);
        check_field("cpu_count",     32'(want.rec.cpu_count),     32'(out_cpu_count));
        check_field("gpu_count",     32'(want.rec.gpu_count),     32'(out_gpu_count));
        check_field("memory_amount", 32'(want.rec.memory_amount), 32'(out_memory_amount));
        check_field("run_time",      32'(want.rec.run_time),      32'(out_run_time));
        check_field("priority",      32'(16'(want.rec.prio)),     32'(16'(out_priority)));
        check_field("last",          32'(want.last),              32'(out_last));
      end
    end
  end

  initial begin
    cmd_t c;
    int   counted;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_opcode        <= OP_INSERT;
    in_job_tag       <= '0;
    in_user_tag      <= '0;
    in_cpu_count     <= '0;
    in_gpu_count     <= '0;
    in_memory_amount <= '0;
    in_run_time      <= '0;
    in_priority_req  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed();
    foreach (dir_rows[i]) issue(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].status);
    directed_cmds = cmds_sent;

    for (int ph = 0; ph < 4; ph++) begin
      tx_pct = TX_IDLE[ph];
      rx_pct = RX_STALL[ph];
      // long hold-off while the sender keeps pushing: block backs up
      if (ph == 0) hold_request = 1'b1;
      for (int k = 0; k < FILL_BURST; k++) issue(random_command(1'b1), 1'b0, ST_RECORD);
      counted = FILL_BURST;
      while (counted < PHASE_ITEMS) begin
        c = random_command(1'b0);
        issue(c, 1'b0, ST_RECORD);
        if (c.opcode != OP_SPARE_A && c.opcode != OP_SPARE_B) counted++;
      end
    end
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d commands (%0d from the table), %0d result beats checked",
             cmds_sent, directed_cmds, beats_seen);
    $display("  %0d refused inserts, four idle/stall mixes, one %0d-cycle hold-off",
             refused_seen, HOLD_CYCLES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
